[src/sorted_table_binary_search_top_assert.svh]
// Assertion macros used by the checker file of the sorted-table search.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stbs check failed");

// Next-cycle implication, ignored while reset is high.
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stbs check failed");

// Next-cycle implication that also covers reset itself.
`define STBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stbs check failed");

`endif

[src/stbs_pkg.sv]
// Shared constants and controller/datapath interface types for the sorted-table search.
`default_nettype none
package stbs_pkg;

   localparam int unsigned STBS_DEPTH = 256;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_EXACT = 2'd1;
   localparam logic [1:0] MODE_FIRST = 2'd2;
   localparam logic [1:0] MODE_LAST  = 2'd3;

   typedef struct packed {
      logic load;     // write one table entry from the input word
      logic start;    // latch key and mode, open the search window
      logic read;     // issue a table read at the current midpoint
      logic step;     // compare read data and narrow the window
      logic publish;  // move the search result into the output register
   } stbs_cmd_type;

   typedef struct packed {
      logic live;     // window still open and no exact hit yet
      logic out_free; // output register can take a new result this cycle
   } stbs_status_type;

endpackage
`default_nettype wire

[src/sorted_table_binary_search_top.sv]
// Top level of the sorted-table binary search block.
// Load word: accepted without raising req_stall, writes one table entry, no result word.
// Search word: each probe is a memory read, then a compare; at most
//   clog2(DEPTH)+1 probes; the result register loads in PUBLISH once the output is free.
// One search at a time; req_stall is high from accept until the result is registered.
// Synchronous active-high reset clears control state and entry_count; table is not cleared.
`default_nettype none
module sorted_table_binary_search_top #(
   parameter int unsigned DEPTH = stbs_pkg::STBS_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration: entry_count
   input  wire logic               csr_write_en,
   input  wire logic [8:0]         csr_write_data,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic [7:0]         req_slot,
   input  wire logic signed [31:0] req_key,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic [7:0]              rsp_position
);
   import stbs_pkg::*;

   // controller drives one-hot-ish commands, datapath answers with window status
   stbs_cmd_type    cmd;
   stbs_status_type status;

   // The controller walks IDLE -> ISSUE/COMPARE pairs -> PUBLISH.
   // The probe loop ends when the window closes or an exact-mode hit lands.
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath owns the table memory, the count register and the output
   // register, so a finished word can sit at the output while the next
   // request is already being taken.
   stbs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_slot       (req_slot),
      .req_key        (req_key),
      .req_mode       (req_mode),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position)
   );

endmodule
`default_nettype wire

[src/stbs_dpath.sv]
// Datapath: table memory, search window, compare logic and output register.
`default_nettype none
module stbs_dpath #(
   parameter int unsigned DEPTH = stbs_pkg::STBS_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [8:0]             csr_write_data,
   input  wire logic [7:0]             req_slot,
   input  wire logic signed [31:0]     req_key,
   input  wire logic [1:0]             req_mode,
   input  wire stbs_pkg::stbs_cmd_type cmd,
   output stbs_pkg::stbs_status_type   status,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [7:0]                  rsp_position
);
   import stbs_pkg::*;

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic signed [31:0] table_mem [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [IW-1:0]      mid_ff;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;    // one past the last open index
   logic [8:0]         count_ff;
   logic signed [31:0] key_ff;
   logic [1:0]         mode_ff;
   logic               stop_ff, stop_in;
   logic               hit_ff, hit_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [7:0]         rsp_position_ff;

   logic [CW-1:0]      span_w;
   logic [CW:0]        sum_w;
   logic [IW-1:0]      mid_w;
   logic [CW-1:0]      mid_ext_w;
   logic               slot_ok_w;

   // clamp the configured count to the table depth
   always_comb begin
      if (32'(count_ff) > 32'(DEPTH)) begin
         span_w = CW'(DEPTH);
      end else begin
         span_w = CW'(count_ff);
      end
   end

   // floor((low + high) / 2) with high = hi_ff - 1; only used while lo_ff < hi_ff
   assign sum_w     = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
   assign mid_w     = IW'(sum_w >> 1);
   assign mid_ext_w = CW'(mid_ff);
   assign slot_ok_w = 32'(req_slot) < 32'(DEPTH);

   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      stop_in    = stop_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      if (cmd.start) begin
         lo_in   = '0;
         hi_in   = span_w;
         stop_in = 1'b0;
         hit_in  = 1'b0;
      end else if (cmd.step) begin
         if (key_ff < rd_data_ff) begin
            hi_in = mid_ext_w;
         end else if (key_ff > rd_data_ff) begin
            lo_in = mid_ext_w + CW'(1);
         end else begin
            hit_in     = 1'b1;
            hit_idx_in = mid_ff;
            case (mode_ff)
               MODE_EXACT: stop_in = 1'b1;
               MODE_FIRST: hi_in   = mid_ext_w;
               default:    lo_in   = mid_ext_w + CW'(1);
            endcase
         end
      end
   end

   // table memory: one write port for loads, one registered read port for probes
   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok_w) begin
         table_mem[IW'(req_slot)] <= req_key;
      end
      if (cmd.read) begin
         rd_data_ff <= table_mem[mid_w];
         mid_ff     <= mid_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_en) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         stop_ff <= stop_in;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      hit_idx_ff <= hit_idx_in;
      if (cmd.start) begin
         key_ff  <= req_key;
         mode_ff <= req_mode;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= hit_ff ? 8'(hit_idx_ff) : 8'd0;
      end
   end

   assign status.live     = (lo_ff < hi_ff) && !stop_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule
`default_nettype wire

[src/stbs_ctrl.sv]
// Controller: sequences loads, probe read/compare pairs and result hand-off.
`default_nettype none
module stbs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [1:0]                req_mode,
   output logic                           req_stall,
   output stbs_pkg::stbs_cmd_type         cmd,
   input  wire stbs_pkg::stbs_status_type status
);
   import stbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_COMPARE,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (status.live) begin
               cmd.read = 1'b1;
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_PUBLISH;
            end
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = ST_ISSUE;
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

[src/stbs_checker.sv]
// Port-level checker for the sorted-table search, bound to the top level.
`default_nettype none
`include "sorted_table_binary_search_top_assert.svh"
module stbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_mode,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [7:0]  rsp_position
);
   import stbs_pkg::*;

   logic load_take_w;
   logic search_take_w;

   assign load_take_w   = req_valid && !req_stall && (req_mode == MODE_LOAD);
   assign search_take_w = req_valid && !req_stall && (req_mode != MODE_LOAD);

   `STBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_found) && $stable(rsp_position))
   `STBS_ASSERT_NOW(a_miss_pos_zero, clock, reset, rsp_valid && !rsp_found,
      rsp_position == 8'd0)
   `STBS_ASSERT_NEXT(a_load_one_cycle, clock, reset, load_take_w, !req_stall)
   `STBS_ASSERT_NEXT(a_search_busy, clock, reset, search_take_w, req_stall)
   `STBS_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position)
);
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the sorted-table binary search block.
module testbench;
   import stbs_pkg::*;

   // Cycles without any accepted word before the run is declared hung.
   localparam int IDLE_LIMIT   = 4000;
   // Worst search: 9 probes, each a read then a compare, before the result is registered.
   localparam int SETTLE_WAIT  = 40;
   localparam int ITEMS_TARGET = 1150;
   localparam int PRINT_CAP    = 40;

   typedef struct packed {
      logic       found;
      logic [7:0] position;
   } search_result_type;

   // Mirror of the table and entry_count, plus the results still owed by the block.
   class search_scoreboard_type;
      logic signed [31:0] entries [STBS_DEPTH];
      logic [8:0]         count;
      search_result_type  expected_results [$];
      int                 errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         count  = '0;
         errors = 0;
      endfunction

      function void set_entry_count(logic [8:0] value);
         count = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Binary search over entries 0..n-1; n saturates at the table depth.
      function search_result_type predict_search(logic [1:0] mode, logic signed [31:0] key);
         int lo, hi, mid, hit;
         search_result_type r;
         lo  = 0;
         hi  = ((count > STBS_DEPTH) ? STBS_DEPTH : int'(count)) - 1;
         hit = -1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < entries[mid[7:0]]) begin
               hi = mid - 1;
            end else if (key > entries[mid[7:0]]) begin
               lo = mid + 1;
            end else begin
               hit = mid;
               if (mode == MODE_EXACT) break;
               else if (mode == MODE_FIRST) hi = mid - 1;
               else lo = mid + 1;
            end
         end
         r.found    = (hit >= 0);
         r.position = (hit >= 0) ? hit[7:0] : 8'd0;
         return r;
      endfunction

      // Accepted request word: loads update the mirror, searches owe one result.
      function void note_word(logic [1:0] mode, logic [7:0] slot, logic signed [31:0] key);
         if (mode == MODE_LOAD) entries[slot] = key;
         else expected_results.push_back(predict_search(mode, key));
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
      endtask

      task check_result(logic found, logic [7:0] position);
         search_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: found=%0b position=%0d",
                                      found, position));
            return;
         end
         want = expected_results.pop_front();
         if (found !== want.found)
            report_mismatch($sformatf("found=%0b, want %0b", found, want.found));
         if (position !== want.position)
            report_mismatch($sformatf("position=%0d, want %0d", position, want.position));
      endtask
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_write_en   = 1'b0;
   logic [8:0]         csr_write_data = '0;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode       = MODE_LOAD;
   logic [7:0]         req_slot       = '0;
   logic signed [31:0] req_key        = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic               rsp_found;
   logic [7:0]         rsp_position;

   search_scoreboard_type sb = new();

   // Percent chance per cycle that the sender idles / the receiver stalls.
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   // Slots that have been loaded at least once; searches never probe past these.
   bit  written [STBS_DEPTH];

   // Counts of 1..511 clamp to windows of 1..256; probe windows never see an entry that was not loaded.
   int unsigned count_plan [16] = '{256, 511, 1, 2, 255, 3, 128, 5,
                                    16, 300, 9, 64, 33, 4, 47, 20};

   always #10 clock = ~clock;

   sorted_table_binary_search_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_slot       (req_slot),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position)
   );

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Receiver: random stall per cycle at the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= roll(recv_stall_pct);
   end

   // Result checking and the hang watchdog. Values read here are the ones the
   // edge sampled, since all drivers update through nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_found, rsp_position);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TIMEOUT: no word accepted for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one request word and hold it until accepted. A random gap may
   // come first; valid is only dropped at a step where it is not also raised.
   task automatic send_word(logic [1:0] mode, logic [7:0] slot, logic signed [31:0] key);
      if (roll(send_idle_pct)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (roll(send_idle_pct));
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_slot  <= slot;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Noted here rather than in the monitor so the drain check below never
      // misses a search taken at this very edge.
      sb.note_word(mode, slot, key);
      if (mode == MODE_LOAD) written[slot] = 1'b1;
      items_sent++;
   endtask

   // Sender holds off until every owed result is back, then lets any load
   // still in flight retire before the register may change.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_count(logic [8:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_entry_count(value);
   endtask

   function automatic bit prefix_written(int n);
      for (int i = 0; i < n; i++) if (!written[i[7:0]]) return 1'b0;
      return 1'b1;
   endfunction

   // Ascending fill of slots 0..n-1. Small step spans give runs of equal
   // entries; large spans pin the tail at the top of the signed range.
   task automatic fill_sorted(int n);
      longint v, span;
      span = longint'(1) << $urandom_range(30, 0);
      v = longint'(int'($urandom)) - (span * n) / 2;
      for (int i = 0; i < n; i++) begin
         if (i != 0) v += $urandom_range(int'(span));
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         send_word(MODE_LOAD, i[7:0], v[31:0]);
      end
   endtask

   // Search key: mostly a value in the live window, some neighbors of one,
   // the rest fully random. The slot field is don't-care for searches.
   task automatic send_search(int n);
      int unsigned sel;
      logic signed [31:0] key;
      logic [1:0] mode;
      sel  = $urandom_range(99);
      mode = (sel % 3 == 0) ? MODE_EXACT : ((sel % 3 == 1) ? MODE_FIRST : MODE_LAST);
      if (n == 0 || sel < 20) begin
         key = $urandom;
      end else begin
         key = sb.entries[8'($urandom_range(n - 1))];
         if (sel < 35) key = $urandom_range(1) ? key + 1 : key - 1;
      end
      send_word(mode, 8'($urandom_range(255)), key);
   endtask

   // One setting of entry_count: refill the window when needed (small windows
   // often), then searches with the odd stray load that can unsort the table.
   task automatic run_phase(int n);
      int phase_items;
      phase_items = 0;
      while (phase_items < 70) begin
         if (!prefix_written(n) || (n <= 64 && $urandom_range(1) == 1)) begin
            fill_sorted(n);
            phase_items += n;
         end
         repeat (12) begin
            if ($urandom_range(11) == 0) begin
               send_word(MODE_LOAD, 8'($urandom_range(255)), $urandom);
               phase_items++;
            end
            send_search(n);
            phase_items++;
         end
      end
   endtask

   initial begin
      int p;
      int unsigned n_cfg;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table right after reset: every mode misses.
      send_word(MODE_EXACT, 8'd0, 32'sd0);
      send_word(MODE_FIRST, 8'd255, 32'sh8000_0000);
      send_word(MODE_LAST, 8'd17, 32'sh7fff_ffff);

      // Six entries with both signed extremes and a run of three equal values.
      set_count(9'd6);
      send_word(MODE_LOAD, 8'd0, 32'sh8000_0000);
      send_word(MODE_LOAD, 8'd1, -32'sd5);
      send_word(MODE_LOAD, 8'd2, 32'sd7);
      send_word(MODE_LOAD, 8'd3, 32'sd7);
      send_word(MODE_LOAD, 8'd4, 32'sd7);
      send_word(MODE_LOAD, 8'd5, 32'sh7fff_ffff);
      send_word(MODE_EXACT, 8'd0, 32'sd7);
      send_word(MODE_FIRST, 8'd0, 32'sd7);
      send_word(MODE_LAST, 8'd0, 32'sd7);
      send_word(MODE_EXACT, 8'd0, 32'sh8000_0000);
      send_word(MODE_FIRST, 8'd0, 32'sh8000_0000);
      send_word(MODE_EXACT, 8'd0, 32'sh7fff_ffff);
      send_word(MODE_LAST, 8'd0, 32'sh7fff_ffff);
      send_word(MODE_EXACT, 8'd0, -32'sd4);
      send_word(MODE_FIRST, 8'd0, 32'sh8000_0001);

      // Random phases: idling mode cycles none / sender / receiver / both.
      p = 0;
      while (items_sent < ITEMS_TARGET) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         n_cfg = count_plan[4'(p % 16)];
         set_count(n_cfg[8:0]);
         run_phase((n_cfg > STBS_DEPTH) ? STBS_DEPTH : int'(n_cfg));
         p++;
      end

      drain();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
